// File: rtl/core/look_at_view_matrix_top_macros.svh
// assertion macros shared by the look-at view matrix rtl
`ifndef LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds in a cycle, consequent holds in the same cycle
`define LAV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lav assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define LAV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lav assertion failed");

`else

`define LAV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LAV_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/lav_pkg.sv
// types, widths and rounding helper for the look-at view matrix pipeline
package lav_pkg;

    localparam int LAV_FRAC   = 14;
    localparam int ROT_W      = 16;
    localparam int ZOOM_W     = 16;
    localparam int DIST_W     = 20;
    localparam int EYE_W      = 30;
    localparam int VEC_W      = 32;
    localparam int MAG_W      = 31;
    localparam int NRM_W      = 30;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int QUO_W      = LAV_FRAC + 1;
    localparam int NUM_W      = NRM_W + LAV_FRAC + 1;
    localparam int BAS_W      = 16;
    localparam int VB_W       = 17;
    localparam int SHIFT_W    = 28;
    localparam int EYE_SHIFT  = 8 + LAV_FRAC;

    localparam logic signed [DIST_W-1:0] DIST_RESET = 20'sd256;

    typedef struct packed {
        logic signed [ROT_W-1:0]  rot_r0c0;
        logic signed [ROT_W-1:0]  rot_r0c1;
        logic signed [ROT_W-1:0]  rot_r0c2;
        logic signed [ROT_W-1:0]  rot_r1c0;
        logic signed [ROT_W-1:0]  rot_r1c1;
        logic signed [ROT_W-1:0]  rot_r1c2;
        logic signed [ROT_W-1:0]  rot_r2c0;
        logic signed [ROT_W-1:0]  rot_r2c1;
        logic signed [ROT_W-1:0]  rot_r2c2;
        logic        [ZOOM_W-1:0] zoom_factor;
    } lav_in_t;

    typedef struct packed {
        logic signed [BAS_W-1:0]   right_x;
        logic signed [BAS_W-1:0]   right_y;
        logic signed [BAS_W-1:0]   right_z;
        logic signed [BAS_W-1:0]   up_x;
        logic signed [BAS_W-1:0]   up_y;
        logic signed [BAS_W-1:0]   up_z;
        logic signed [BAS_W-1:0]   back_x;
        logic signed [BAS_W-1:0]   back_y;
        logic signed [BAS_W-1:0]   back_z;
        logic signed [SHIFT_W-1:0] shift_u;
        logic signed [SHIFT_W-1:0] shift_v;
        logic signed [SHIFT_W-1:0] shift_w;
    } lav_out_t;

    typedef logic [2:0][VEC_W-1:0] lav_vec_t;
    typedef logic [2:0][BAS_W-1:0] lav_bas_t;

    // data that rides along a normalizer: eye point and one vector of three 16-bit parts
    typedef struct packed {
        logic [2:0][EYE_W-1:0] eye;
        lav_bas_t              vec;
    } lav_side_t;

    // shift right by sh with halves rounded away from zero
    function automatic logic signed [63:0] lav_round(input logic signed [63:0] x,
                                                     input int sh);
        logic [63:0] mag;
        logic [63:0] res;
        mag = x[63] ? 64'(-x) : 64'(x);
        res = (mag + (64'd1 << (sh - 1))) >> sh;
        return x[63] ? -$signed(res) : $signed(res);
    endfunction

endpackage

// File: rtl/core/lav_front.sv
// front stages: distance times zoom, rounded eye point and signed third column
module lav_front import lav_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DIST_W-1:0] eye_dist,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  lav_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output lav_vec_t                 out_vec,
    output lav_side_t                out_side
);

    localparam int NS  = 3;
    localparam int S_W = DIST_W + ZOOM_W + 1;
    localparam int P_W = S_W + ROT_W;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    logic signed [S_W-1:0]   s_reg;
    lav_bas_t                c1_reg [NS];
    lav_bas_t                c2_reg;
    logic signed [P_W-1:0]   prod_reg [3];
    lav_vec_t                vec1_reg;
    lav_vec_t                vec2_reg;
    logic [2:0][EYE_W-1:0]   eye_reg;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s_reg     <= eye_dist * $signed({1'b0, in_data.zoom_factor});
            c1_reg[0] <= {in_data.rot_r2c1, in_data.rot_r1c1, in_data.rot_r0c1};
            c2_reg    <= {in_data.rot_r2c2, in_data.rot_r1c2, in_data.rot_r0c2};
        end
        if (adv[1])
        begin
            c1_reg[1] <= c1_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= s_reg * $signed(c2_reg[i]);
                // w follows the sign of distance times zoom, zero when that is zero
                if (s_reg == '0)
                begin
                    vec1_reg[i] <= '0;
                end
                else if (s_reg[S_W-1])
                begin
                    vec1_reg[i] <= -VEC_W'($signed(c2_reg[i]));
                end
                else
                begin
                    vec1_reg[i] <= VEC_W'($signed(c2_reg[i]));
                end
            end
        end
        if (adv[2])
        begin
            c1_reg[2] <= c1_reg[1];
            vec2_reg  <= vec1_reg;
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= EYE_W'(lav_round(64'(prod_reg[i]), EYE_SHIFT));
            end
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign out_vec       = vec2_reg;
    assign out_side.eye  = eye_reg;
    assign out_side.vec  = c1_reg[NS-1];

endmodule

// File: rtl/core/lav_unit.sv
// pipelined vector normalizer: scale, sum of squares, square root, divide
`include "look_at_view_matrix_top_macros.svh"
module lav_unit import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lav_vec_t  in_vec,
    input  lav_side_t in_side,
    output logic      out_valid,
    input  logic      out_ready,
    output lav_bas_t  out_vec,
    output lav_side_t out_side
);

    localparam int ST_SH  = 1;
    localparam int ST_NRM = 2;
    localparam int ST_SQ  = 3;
    localparam int ST_SUM = 4;
    localparam int ST_RT  = 5;
    localparam int ST_NUM = ST_RT + SQRT_STEPS;
    localparam int ST_DV  = ST_NUM + 1;
    localparam int ST_OUT = ST_DV + QUO_W;
    localparam int NS     = ST_OUT + 1;
    localparam int SH_W   = $clog2(MAG_W);

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    lav_side_t                side_reg [0:ST_OUT];
    logic [2:0]               neg_reg  [0:ST_OUT-1];
    logic                     zero_reg [ST_SH:ST_OUT-1];
    logic [2:0][MAG_W-1:0]    mag0_reg;
    logic [2:0][MAG_W-1:0]    mag1_reg;
    logic                     rsh_reg;
    logic [SH_W-1:0]          lsh_reg;
    logic [2:0][NRM_W-1:0]    nm_reg   [ST_NRM:ST_NUM-1];
    logic [2:0][2*NRM_W-1:0]  sq_reg;
    logic [63:0]              n_reg    [ST_SUM:ST_NUM-1];
    logic [63:0]              res_reg  [ST_SUM:ST_NUM-1];
    logic [ROOT_W-1:0]        norm_reg [ST_NUM:ST_OUT-2];
    logic [2:0][NUM_W-1:0]    rem_reg  [ST_NUM:ST_OUT-2];
    logic [2:0][QUO_W-1:0]    quo_reg  [ST_DV:ST_OUT-1];
    lav_bas_t                 out_reg;

    logic [MAG_W-1:0] top;
    logic [SH_W-1:0]  pos;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        top = mag0_reg[0] | mag0_reg[1] | mag0_reg[2];
        pos = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (top[b])
            begin
                pos = SH_W'(b);
            end
        end
    end

    // sideband and signs move with the item
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[0][i] <= in_vec[i][VEC_W-1];
                mag0_reg[i]   <= in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
            end
        end
        for (int k = 1; k <= ST_OUT; k++)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        for (int k = 1; k < ST_OUT; k++)
        begin
            if (adv[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // scale so the largest magnitude sits in [2^29, 2^30)
    always_ff @(posedge clk)
    begin
        if (adv[ST_SH])
        begin
            mag1_reg         <= mag0_reg;
            zero_reg[ST_SH]  <= (top == '0);
            rsh_reg          <= top[MAG_W-1];
            lsh_reg          <= (top == '0) ? '0 : SH_W'(NRM_W - 1) - pos;
        end
        for (int k = ST_SH + 1; k < ST_OUT; k++)
        begin
            if (adv[k])
            begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
        if (adv[ST_NRM])
        begin
            for (int i = 0; i < 3; i++)
            begin
                nm_reg[ST_NRM][i] <= rsh_reg ? NRM_W'(mag1_reg[i] >> 1)
                                             : NRM_W'(mag1_reg[i] << lsh_reg);
            end
        end
        for (int k = ST_NRM + 1; k < ST_NUM; k++)
        begin
            if (adv[k])
            begin
                nm_reg[k] <= nm_reg[k-1];
            end
        end
        if (adv[ST_SQ])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= nm_reg[ST_SQ-1][i] * nm_reg[ST_SQ-1][i];
            end
        end
        if (adv[ST_SUM])
        begin
            n_reg[ST_SUM]   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            res_reg[ST_SUM] <= '0;
        end
    end

    // integer square root, one result bit per stage
    genvar j;
    generate
        for (j = 0; j < SQRT_STEPS; j++)
        begin : g_root
            localparam int K = ST_RT + j;
            localparam logic [63:0] RT_BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
            logic [63:0] trial;
            assign trial = res_reg[K-1] + RT_BIT;
            if (K < ST_NUM)
            begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (adv[K])
                    begin
                        if (n_reg[K-1] >= trial)
                        begin
                            n_reg[K]   <= n_reg[K-1] - trial;
                            res_reg[K] <= (res_reg[K-1] >> 1) + RT_BIT;
                        end
                        else
                        begin
                            n_reg[K]   <= n_reg[K-1];
                            res_reg[K] <= res_reg[K-1] >> 1;
                        end
                    end
                end
            end
        end
    endgenerate

    // root is complete; build the rounded dividend
    logic [63:0] root_last;
    assign root_last  = res_reg[ST_NUM-1];

    always_ff @(posedge clk)
    begin
        if (adv[ST_NUM])
        begin
            norm_reg[ST_NUM] <= root_last[ROOT_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[ST_NUM][i] <= (NUM_W'(nm_reg[ST_NUM-1][i]) << LAV_FRAC)
                                      + NUM_W'(root_last[ROOT_W-1:1]);
            end
        end
    end

    // restoring divide, one quotient bit per stage
    generate
        for (j = 0; j < QUO_W; j++)
        begin : g_div
            localparam int K = ST_DV + j;
            localparam int B = QUO_W - 1 - j;
            logic [2:0][QUO_W-1:0] q_prev;
            logic [NUM_W-1:0]      dvs;
            logic [2:0]            take;
            if (j == 0)
            begin : g_first
                assign q_prev = '0;
            end
            else
            begin : g_next
                assign q_prev = quo_reg[K-1];
            end
            assign dvs = NUM_W'(norm_reg[K-1]) << B;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    take[i] = rem_reg[K-1][i] >= dvs;
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv[K])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        quo_reg[K][i] <= take[i] ? (q_prev[i] | (QUO_W'(1) << B)) : q_prev[i];
                    end
                end
            end
            if (K < ST_OUT - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (adv[K])
                    begin
                        norm_reg[K] <= norm_reg[K-1];
                        for (int i = 0; i < 3; i++)
                        begin
                            rem_reg[K][i] <= take[i] ? rem_reg[K-1][i] - dvs : rem_reg[K-1][i];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (zero_reg[ST_OUT-1])
                begin
                    out_reg[i] <= '0;
                end
                else if (neg_reg[ST_OUT-1][i])
                begin
                    out_reg[i] <= -BAS_W'(quo_reg[ST_OUT-1][i]);
                end
                else
                begin
                    out_reg[i] <= BAS_W'(quo_reg[ST_OUT-1][i]);
                end
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_vec   = out_reg;
    assign out_side  = side_reg[ST_OUT];

    `LAV_ASSERT_IMP(a_nrm_lead, clk, rst_n, vld_reg[ST_NRM] && !zero_reg[ST_NRM], (nm_reg[ST_NRM][0][NRM_W-1] || nm_reg[ST_NRM][1][NRM_W-1] || nm_reg[ST_NRM][2][NRM_W-1]))
    `LAV_ASSERT_IMP(a_root_low, clk, rst_n, vld_reg[ST_NUM] && !zero_reg[ST_NUM], norm_reg[ST_NUM][ROOT_W-1:NRM_W-1] != '0)
    `LAV_ASSERT_IMP(a_quo_max, clk, rst_n, vld_reg[ST_OUT-1] && !zero_reg[ST_OUT-1], (quo_reg[ST_OUT-1][0] <= (QUO_W'(1) << LAV_FRAC)) && (quo_reg[ST_OUT-1][1] <= (QUO_W'(1) << LAV_FRAC)) && (quo_reg[ST_OUT-1][2] <= (QUO_W'(1) << LAV_FRAC)))

endmodule

// File: rtl/core/lav_cross.sv
// cross product of the rotated up vector with w, one stage
module lav_cross import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lav_bas_t  in_w,
    input  lav_side_t in_side,
    output logic      out_valid,
    input  logic      out_ready,
    output lav_vec_t  out_vec,
    output lav_side_t out_side
);

    logic                     vld_reg;
    logic                     adv;
    logic signed [VEC_W-1:0]  t_reg [3];
    logic [2:0][EYE_W-1:0]    eye_reg;
    lav_bas_t                 w_reg;

    assign adv      = !vld_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye_reg  <= in_side.eye;
            w_reg    <= in_w;
            t_reg[0] <= $signed(in_side.vec[1]) * $signed(in_w[2])
                      - $signed(in_side.vec[2]) * $signed(in_w[1]);
            t_reg[1] <= $signed(in_side.vec[2]) * $signed(in_w[0])
                      - $signed(in_side.vec[0]) * $signed(in_w[2]);
            t_reg[2] <= $signed(in_side.vec[0]) * $signed(in_w[1])
                      - $signed(in_side.vec[1]) * $signed(in_w[0]);
        end
    end

    assign out_valid    = vld_reg;
    assign out_vec      = {t_reg[2], t_reg[1], t_reg[0]};
    assign out_side.eye = eye_reg;
    assign out_side.vec = w_reg;

endmodule

// File: rtl/core/lav_back.sv
// back stages: v = w x u, translation dot products, saturation, output register
module lav_back import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lav_bas_t  in_u,
    input  lav_side_t in_side,
    output logic      out_valid,
    input  logic      out_ready,
    output lav_out_t  out_data
);

    localparam int NS  = 5;
    localparam int D_W = EYE_W + VB_W;
    localparam int T_W = D_W + 2;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    lav_bas_t                u0_reg;
    lav_bas_t                w0_reg;
    logic [2:0][EYE_W-1:0]   eye0_reg;
    logic signed [VEC_W-1:0] cp_reg  [6];
    lav_bas_t                u1_reg;
    lav_bas_t                w1_reg;
    logic [2:0][EYE_W-1:0]   eye1_reg;
    logic signed [VB_W-1:0]  v1_reg  [3];
    logic signed [VB_W-1:0]  bas2_reg [3][3];
    logic signed [D_W-1:0]   dp_reg  [3][3];
    logic signed [VB_W-1:0]  bas3_reg [3][3];
    logic signed [T_W-1:0]   sum_reg [3];
    lav_out_t                out_reg;

    logic signed [VB_W-1:0]  bas1 [3][3];
    logic signed [BAS_W-1:0] bq   [3][3];
    logic signed [SHIFT_W-1:0] tq [3];

    function automatic logic signed [BAS_W-1:0] sat_bas(input logic signed [VB_W-1:0] x);
        if (x > VB_W'(32767))
        begin
            return 16'sd32767;
        end
        else if (x < -VB_W'(32768))
        begin
            return -16'sd32768;
        end
        return BAS_W'(x);
    endfunction

    function automatic logic signed [SHIFT_W-1:0] sat_shift(input logic signed [T_W-1:0] x);
        logic signed [63:0] r;
        r = -lav_round(64'(x), LAV_FRAC);
        if (r > 64'sd134217727)
        begin
            return 28'sd134217727;
        end
        else if (r < -64'sd134217728)
        begin
            return -28'sd134217728;
        end
        return SHIFT_W'(r);
    endfunction

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // basis rows u, v, w, each widened for the dot products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bas1[0][i] = VB_W'($signed(u1_reg[i]));
            bas1[1][i] = v1_reg[i];
            bas1[2][i] = VB_W'($signed(w1_reg[i]));
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bq[k][i] = sat_bas(bas3_reg[k][i]);
            end
            tq[k] = sat_shift(sum_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            u0_reg    <= in_u;
            w0_reg    <= in_side.vec;
            eye0_reg  <= in_side.eye;
            cp_reg[0] <= $signed(in_side.vec[1]) * $signed(in_u[2]);
            cp_reg[1] <= $signed(in_side.vec[2]) * $signed(in_u[1]);
            cp_reg[2] <= $signed(in_side.vec[2]) * $signed(in_u[0]);
            cp_reg[3] <= $signed(in_side.vec[0]) * $signed(in_u[2]);
            cp_reg[4] <= $signed(in_side.vec[0]) * $signed(in_u[1]);
            cp_reg[5] <= $signed(in_side.vec[1]) * $signed(in_u[0]);
        end
        if (adv[1])
        begin
            u1_reg    <= u0_reg;
            w1_reg    <= w0_reg;
            eye1_reg  <= eye0_reg;
            v1_reg[0] <= VB_W'(lav_round(64'(cp_reg[0] - cp_reg[1]), LAV_FRAC));
            v1_reg[1] <= VB_W'(lav_round(64'(cp_reg[2] - cp_reg[3]), LAV_FRAC));
            v1_reg[2] <= VB_W'(lav_round(64'(cp_reg[4] - cp_reg[5]), LAV_FRAC));
        end
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    bas2_reg[k][i] <= bas1[k][i];
                    dp_reg[k][i]   <= $signed(eye1_reg[i]) * bas1[k][i];
                end
            end
        end
        if (adv[3])
        begin
            bas3_reg <= bas2_reg;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= T_W'(dp_reg[k][0]) + T_W'(dp_reg[k][1]) + T_W'(dp_reg[k][2]);
            end
        end
        if (adv[4])
        begin
            out_reg.right_x <= bq[0][0];
            out_reg.right_y <= bq[0][1];
            out_reg.right_z <= bq[0][2];
            out_reg.up_x    <= bq[1][0];
            out_reg.up_y    <= bq[1][1];
            out_reg.up_z    <= bq[1][2];
            out_reg.back_x  <= bq[2][0];
            out_reg.back_y  <= bq[2][1];
            out_reg.back_z  <= bq[2][2];
            out_reg.shift_u <= tq[0];
            out_reg.shift_v <= tq[1];
            out_reg.shift_w <= tq[2];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

endmodule

// File: rtl/core/look_at_view_matrix_top.sv
// look-at view matrix: camera rotation and zoom in, view basis and translation out
//
// in channel: one word per camera pose (in_valid/in_ready): the 3x3 rotation
// in Q2.14 and the zoom in Q8.8. out channel: one word per pose
// (out_valid/out_ready): right, up and back basis vectors in Q2.14 and the
// saturated translation row in Q20.8. cfg_we/cfg_data write the Q12.8 eye
// distance; write it only while no pose is in flight. a pose passes 3 front
// stages, two 53-stage normalizers (31 square-root stages and 15 divide
// stages each, one bit per stage), one cross-product stage and 5 back stages
// on its way from acceptance to out_valid. throughput is one pose per cycle
// while out_ready is high; every stage holds a valid bit and moves on when
// the stage after it is empty or moving, so bubbles close up.
// reset clears all valid bits and sets the eye distance to 1.0.
// when out_ready is low the result waits in the output register and the
// stages behind it keep filling; in_ready falls only once all are full.
`include "look_at_view_matrix_top_macros.svh"
module look_at_view_matrix_top import lav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DIST_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  lav_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lav_out_t          out_data
);

    logic signed [DIST_W-1:0] dist_reg;

    logic      fr_valid;
    logic      fr_ready;
    lav_vec_t  fr_vec;
    lav_side_t fr_side;
    logic      w_valid;
    logic      w_ready;
    lav_bas_t  w_vec;
    lav_side_t w_side;
    logic      cr_valid;
    logic      cr_ready;
    lav_vec_t  cr_vec;
    lav_side_t cr_side;
    logic      u_valid;
    logic      u_ready;
    lav_bas_t  u_vec;
    lav_side_t u_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_RESET;
        end
        else if (cfg_we)
        begin
            dist_reg <= $signed(cfg_data);
        end
    end

    lav_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .eye_dist  (dist_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_vec   (fr_vec),
        .out_side  (fr_side)
    );

    // normalizes the third column into w
    lav_unit u_norm_w
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_vec    (fr_vec),
        .in_side   (fr_side),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_vec   (w_vec),
        .out_side  (w_side)
    );

    lav_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_w      (w_vec),
        .in_side   (w_side),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_vec   (cr_vec),
        .out_side  (cr_side)
    );

    // normalizes up cross w into u
    lav_unit u_norm_u
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .in_vec    (cr_vec),
        .in_side   (cr_side),
        .out_valid (u_valid),
        .out_ready (u_ready),
        .out_vec   (u_vec),
        .out_side  (u_side)
    );

    lav_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u_valid),
        .in_ready  (u_ready),
        .in_u      (u_vec),
        .in_side   (u_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `LAV_ASSERT_IMP(a_empty_out_ready, clk, rst_n, !out_valid, in_ready)
    `LAV_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_we, dist_reg == $signed($past(cfg_data)))

endmodule

// File: test/look_at_view_matrix_top_tb.sv
// self-checking testbench for the look-at view matrix block
module look_at_view_matrix_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    localparam int DRAIN_CYCLES = 130;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 200;

    typedef longint vec3_t [3];

    typedef struct {
        lav_in_t  word;
        bit       has_golden;
        lav_out_t golden;
    } pose_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    logic [DIST_W-1:0] cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    lav_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lav_out_t out_data;

    longint   eye_dist = 256;
    lav_out_t pending_views[$];
    int       mismatches = 0;
    int       views_checked = 0;
    int       poses_sent = 0;
    int       gap_mode = 1;
    int       ready_pct = 70;
    int       stall_left = 0;
    longint   cycles = 0;
    pose_row_t directed_rows[$];

    look_at_view_matrix_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #1 clk = ~clk;

    function automatic longint round_away(longint x, int sh);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic vec3_t unit_vec(vec3_t a);
        longint unsigned m[3];
        longint unsigned top, n2, nrm, q;
        vec3_t r;
        top = 0;
        n2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (a[i] < 0) ? -a[i] : a[i];
            top |= m[i];
        end
        if (top == 0)
        begin
            r = '{0, 0, 0};
            return r;
        end
        // bring the largest magnitude into [2^29, 2^30)
        while (top >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
            top <<= 1;
        end
        for (int i = 0; i < 3; i++)
            n2 += m[i] * m[i];
        nrm = int_sqrt(n2);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << LAV_FRAC) + nrm / 2) / nrm;
            r[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    function automatic vec3_t cross_vec(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic lav_out_t predict_view(lav_in_t x, longint eye_d);
        vec3_t c1, c2, eye, w, u, v, t;
        vec3_t basis[3];
        longint s, dot, b[9], sh[3];
        lav_out_t o;
        s = eye_d * longint'(x.zoom_factor);
        c1 = '{longint'(x.rot_r0c1), longint'(x.rot_r1c1), longint'(x.rot_r2c1)};
        c2 = '{longint'(x.rot_r0c2), longint'(x.rot_r1c2), longint'(x.rot_r2c2)};
        for (int i = 0; i < 3; i++)
            eye[i] = round_away(s * c2[i], EYE_SHIFT);
        if (s == 0)
            w = '{0, 0, 0};
        else
        begin
            w = unit_vec(c2);
            if (s < 0)
                for (int i = 0; i < 3; i++)
                    w[i] = -w[i];
        end
        u = unit_vec(cross_vec(c1, w));
        t = cross_vec(w, u);
        for (int i = 0; i < 3; i++)
            v[i] = round_away(t[i], LAV_FRAC);
        basis[0] = u;
        basis[1] = v;
        basis[2] = w;
        for (int k = 0; k < 3; k++)
        begin
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                b[k * 3 + i] = clamp_to(basis[k][i], -32768, 32767);
                dot += eye[i] * basis[k][i];
            end
            sh[k] = clamp_to(-round_away(dot, LAV_FRAC), -134217728, 134217727);
        end
        o.right_x = 16'(b[0]); o.right_y = 16'(b[1]); o.right_z = 16'(b[2]);
        o.up_x    = 16'(b[3]); o.up_y    = 16'(b[4]); o.up_z    = 16'(b[5]);
        o.back_x  = 16'(b[6]); o.back_y  = 16'(b[7]); o.back_z  = 16'(b[8]);
        o.shift_u = 28'(sh[0]); o.shift_v = 28'(sh[1]); o.shift_w = 28'(sh[2]);
        return o;
    endfunction

    function automatic void view_fields(lav_out_t o, output longint f[12]);
        f = '{o.right_x, o.right_y, o.right_z, o.up_x, o.up_y, o.up_z,
              o.back_x, o.back_y, o.back_z, o.shift_u, o.shift_v, o.shift_w};
    endfunction

    function automatic lav_in_t make_pose(int a0, int a1, int a2, int b0, int b1,
                                          int b2, int c0, int c1, int c2, int z);
        lav_in_t p;
        p = {16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2),
             16'(c0), 16'(c1), 16'(c2), 16'(z)};
        return p;
    endfunction

    function automatic int rand_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 32768) - 16384;
        else if (r < 80)
            return 0;
        else if (r < 88)
            return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
        else
            return int'($urandom_range(0, 65535));
    endfunction

    function automatic lav_in_t rand_pose();
        int e[9];
        int z, r;
        for (int i = 0; i < 9; i++)
            e[i] = rand_entry();
        r = $urandom_range(0, 99);
        // zero third column, or up column parallel to it
        if (r < 5)
        begin
            e[2] = 0;
            e[5] = 0;
            e[8] = 0;
        end
        else if (r < 10)
        begin
            e[1] = e[2];
            e[4] = e[5];
            e[7] = e[8];
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            z = 0;
        else if (r < 10)
            z = 65535;
        else if (r < 40)
            z = $urandom_range(0, 1023);
        else
            z = $urandom_range(0, 65535);
        return make_pose(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], z);
    endfunction

    function automatic int pick_gap();
        int r;
        if (gap_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_pose(lav_in_t p, bit has_golden, lav_out_t golden);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_views.push_back(has_golden ? golden : predict_view(p, eye_dist));
        poses_sent++;
    endtask

    task automatic drain_then_write(longint new_dist);
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= DIST_W'(new_dist);
        @(posedge clk);
        cfg_we   <= 1'b0;
        eye_dist = new_dist;
    endtask

    // receiver side: random stalls, occasionally long ones
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (ready_pct < 100 && r < 3)
        begin
            stall_left <= $urandom_range(20, 60);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge clk)
    begin
        lav_out_t expv;
        longint fe[12], fg[12];
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h", out_data);
            end
            else
            begin
                expv = pending_views.pop_front();
                view_fields(expv, fe);
                view_fields(out_data, fg);
                views_checked++;
                for (int i = 0; i < 12; i++)
                    if (fe[i] !== fg[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d field %0d: expected %0d got %0d",
                                     views_checked, i, fe[i], fg[i]);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("look_at_view_matrix_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        longint settings[6];
        lav_out_t zero_view, ident_view;
        settings = '{524287, -524288, 0, -256, 1, 0};
        settings[5] = longint'($urandom_range(0, 1048575)) - 524288;
        zero_view = '0;
        ident_view = '0;
        ident_view.right_x = 16384;
        ident_view.up_y    = 16384;
        ident_view.back_z  = 16384;
        ident_view.shift_w = -256;

        directed_rows.push_back('{make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_view});
        directed_rows.push_back('{make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 256),
                                  1, ident_view});
        // zero zoom kills the whole basis
        directed_rows.push_back('{make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0),
                                  1, zero_view});
        directed_rows.push_back('{make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 65535),
                                  0, zero_view});
        directed_rows.push_back('{make_pose(1, 2, 0, 3, 4, 0, 5, 6, 0, 300), 0, zero_view});
        directed_rows.push_back('{make_pose(0, 16384, 16384, 0, 0, 0, 0, 0, 0, 256),
                                  0, zero_view});
        directed_rows.push_back('{make_pose(-16384, -16384, -16384, -16384, -16384, -16384,
                                  -16384, -16384, -16384, 65535), 0, zero_view});
        directed_rows.push_back('{make_pose(16384, 16384, -16384, 16384, -16384, 16384,
                                  -16384, 16384, 16384, 1), 0, zero_view});
        directed_rows.push_back('{make_pose(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 65535), 0, zero_view});
        directed_rows.push_back('{make_pose(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, 65535), 0, zero_view});
        directed_rows.push_back('{make_pose(0, 1, 1, 0, 0, 0, 0, 0, 0, 32768), 0, zero_view});
        directed_rows.push_back('{make_pose(11585, 0, 11585, 0, 16384, 0, -11585, 0, 11585,
                                  512), 0, zero_view});
        directed_rows.push_back('{make_pose(0, -32768, 32767, 0, 32767, -32768, 0, 1, -1,
                                  65535), 0, zero_view});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pose(directed_rows[i].word, directed_rows[i].has_golden,
                      directed_rows[i].golden);

        for (int ph = 0; ph < 6; ph++)
        begin
            // sender waits for every word before the register changes
            drain_then_write(settings[ph]);
            gap_mode  = (ph % 3 != 2);
            ready_pct = (ph == 1) ? 100 : ((ph == 4) ? 30 : 75);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pose(rand_pose(), 0, zero_view);
        end

        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d poses sent, %0d view words checked over seven eye distance settings",
                 poses_sent, views_checked);
        $display("with zero zoom, degenerate columns and random stalls on both sides");
        if (mismatches == 0 && pending_views.size() == 0)
            $display("look_at_view_matrix_top: match");
        else
            $display("look_at_view_matrix_top: mismatch");
        $finish;
    end

endmodule

// File: look_at_view_matrix_top.f
+incdir+rtl/core
rtl/core/lav_pkg.sv
rtl/core/lav_front.sv
rtl/core/lav_unit.sv
rtl/core/lav_cross.sv
rtl/core/lav_back.sv
rtl/core/look_at_view_matrix_top.sv
test/look_at_view_matrix_top_tb.sv
